// ===== rtl/core/lca_pkg.sv =====
// lca_pkg: shared constants, command codes and memory port types of the
// life cellular automaton core
// no dependencies
package lca_pkg;

	// grid size
	localparam int GRID_WIDTH  = 64;
	localparam int GRID_HEIGHT = 48;

	// index widths
	localparam int X_AW   = $clog2(GRID_WIDTH);
	localparam int ROW_AW = $clog2(GRID_HEIGHT);
	localparam int CNT_W  = $clog2(GRID_HEIGHT + 2);

	// field widths
	localparam int CMD_W = 2;
	localparam int XY_W  = 6;

	// command codes
	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_STEP  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

	typedef logic [GRID_WIDTH-1:0] row_t;

	// row memory write request
	typedef struct packed {
		logic              en;
		logic [ROW_AW-1:0] addr;
		row_t              data;
	} mem_wr_t;

	// row memory read request
	typedef struct packed {
		logic              en;
		logic [ROW_AW-1:0] addr;
	} mem_rd_t;

endpackage

// ===== rtl/core/lca_row_mem.sv =====
// lca_row_mem: row store of the cell grid, one write and one read port,
// registered read data, per-row valid bits so unwritten rows read as dead
// depends on lca_pkg
module lca_row_mem (
	input  logic            clk,
	input  logic            arst_n,
	input  lca_pkg::mem_wr_t wr,
	input  lca_pkg::mem_rd_t rd,
	output lca_pkg::row_t   rd_data
);

	lca_pkg::row_t                    rows_q [lca_pkg::GRID_HEIGHT];
	logic [lca_pkg::GRID_HEIGHT-1:0]  valid_q;
	lca_pkg::row_t                    rd_row_s1;
	logic                             rd_vld_s1;

	// storage array and read data
	always_ff @(posedge clk) begin
		if (wr.en) begin
			rows_q[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rd_row_s1 <= rows_q[rd.addr];
		end
	end

	// row valid bits, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
			if (rd.en) begin
				rd_vld_s1 <= valid_q[rd.addr];
			end
		end
	end

	// a row never written reads as all dead
	assign rd_data = rd_vld_s1 ? rd_row_s1 : '0;

endmodule

// ===== rtl/core/lca_row_rule.sv =====
// lca_row_rule: next generation of one grid row from its three-row window
// under the b3/s23 rule, dead cells beyond the edges
// depends on lca_pkg
module lca_row_rule (
	input  lca_pkg::row_t above,
	input  lca_pkg::row_t here,
	input  lca_pkg::row_t below,
	output lca_pkg::row_t next_row
);

	localparam int W = lca_pkg::GRID_WIDTH;

	logic [W+1:0] a_ext;
	logic [W+1:0] h_ext;
	logic [W+1:0] b_ext;
	logic [3:0]   nbr [W];

	// pad the window with dead cells at both edges
	assign a_ext = {1'b0, above, 1'b0};
	assign h_ext = {1'b0, here, 1'b0};
	assign b_ext = {1'b0, below, 1'b0};

	// neighbor count and rule for each cell
	always_comb begin
		for (int x = 0; x < W; x++) begin
			nbr[x] = 4'(a_ext[x]) + 4'(a_ext[x+1]) + 4'(a_ext[x+2])
				+ 4'(h_ext[x]) + 4'(h_ext[x+2])
				+ 4'(b_ext[x]) + 4'(b_ext[x+1]) + 4'(b_ext[x+2]);
			next_row[x] = (nbr[x] == 4'd3) || (here[x] && (nbr[x] == 4'd2));
		end
	end

endmodule

// ===== rtl/core/life_cellular_automaton.sv =====
// life_cellular_automaton: top level, command sequencer, generation sweep
// and output register of the game of life core
// depends on lca_pkg, lca_row_mem, lca_row_rule
//
// channel  dir  tdata fields (lowest bit up)
// s_*      in   command[1:0] cell_x[7:2] cell_y[13:8] cell_value[14] pad[15]
// m_*      out  cell_state[0] any_changed[1] pad[7:2]
//
// write and read: the row is fetched in ST_FETCH, the result fields are registered
// in ST_LOAD and the result enters the output register from ST_DONE, after which
// s_tready returns; an advance first sweeps the grid in ST_SWEEP, then passes
// through ST_FETCH, ST_LOAD and ST_DONE: the row rule unit is used once per row
// while the single row memory streams the grid, then the addressed row is fetched
// s_tready is high only when no command is in progress
// a result waits in the output register until m_tready; a new command may be
// taken meanwhile and holds in its last state until the register frees
// reset clears all cells at once through the row valid bits
module life_cellular_automaton (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // command, cell_x, cell_y, cell_value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // cell_state, any_changed
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SWEEP = 5'b00010,
		ST_FETCH = 5'b00100,
		ST_LOAD  = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t                         state_q;
	logic [lca_pkg::CMD_W-1:0]      cmd_q;
	logic [lca_pkg::XY_W-1:0]       x_q;
	logic [lca_pkg::XY_W-1:0]       y_q;
	logic                           value_q;
	logic [lca_pkg::CNT_W-1:0]      sweep_cnt_q;
	lca_pkg::row_t                  above_q;
	lca_pkg::row_t                  here_q;
	logic                           changed_q;
	logic                           res_state_q;
	logic                           res_changed_q;
	logic                           out_valid_q;
	logic [7:0]                     out_data_q;

	lca_pkg::mem_wr_t               wr;
	lca_pkg::mem_rd_t               rd;
	lca_pkg::row_t                  rd_data;
	lca_pkg::row_t                  below;
	lca_pkg::row_t                  next_row;
	lca_pkg::row_t                  mod_row;
	logic                           in_range;
	logic                           accept;
	logic                           out_free;
	logic [lca_pkg::X_AW-1:0]       xi;
	logic [lca_pkg::CNT_W-1:0]      row_done;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// addressed cell decode
	assign in_range = ({1'b0, x_q} < 7'(lca_pkg::GRID_WIDTH))
		&& ({5'b0, y_q} < 11'(lca_pkg::GRID_HEIGHT));
	assign xi       = x_q[lca_pkg::X_AW-1:0];
	assign row_done = sweep_cnt_q - lca_pkg::CNT_W'(2);

	// row below the window, dead past the last row
	assign below = (sweep_cnt_q <= lca_pkg::CNT_W'(lca_pkg::GRID_HEIGHT)) ? rd_data : '0;

	// write command merges the new cell into the fetched row
	always_comb begin
		mod_row     = rd_data;
		mod_row[xi] = value_q;
	end

	// memory requests
	always_comb begin
		rd      = '0;
		wr      = '0;
		wr.data = next_row;
		unique case (state_q) inside
			ST_SWEEP: begin
				rd.en   = sweep_cnt_q < lca_pkg::CNT_W'(lca_pkg::GRID_HEIGHT);
				rd.addr = lca_pkg::ROW_AW'(sweep_cnt_q);
				wr.en   = sweep_cnt_q >= lca_pkg::CNT_W'(2);
				wr.addr = lca_pkg::ROW_AW'(row_done);
			end
			ST_FETCH: begin
				rd.en   = in_range;
				rd.addr = lca_pkg::ROW_AW'(y_q);
			end
			ST_LOAD: begin
				wr.en   = in_range && (cmd_q == lca_pkg::CMD_WRITE);
				wr.addr = lca_pkg::ROW_AW'(y_q);
				wr.data = mod_row;
			end
			ST_IDLE, ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	lca_row_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd      (rd),
		.rd_data (rd_data)
	);

	lca_row_rule u_rule (
		.above    (above_q),
		.here     (here_q),
		.below    (below),
		.next_row (next_row)
	);

	// command fields
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= s_tdata[1:0];
			x_q     <= s_tdata[7:2];
			y_q     <= s_tdata[13:8];
			value_q <= s_tdata[14];
		end
	end

	// sweep window, shifted one row per cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			above_q <= '0;
			here_q  <= '0;
		end else if (state_q == ST_SWEEP && sweep_cnt_q != '0) begin
			above_q <= here_q;
			here_q  <= below;
		end
	end

	// result fields
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			if (!in_range) begin
				res_state_q <= 1'b0;
			end else if (cmd_q == lca_pkg::CMD_WRITE) begin
				res_state_q <= value_q;
			end else begin
				res_state_q <= rd_data[xi];
			end
			res_changed_q <= (cmd_q == lca_pkg::CMD_STEP) && changed_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sweep_cnt_q <= '0;
			changed_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						sweep_cnt_q <= '0;
						changed_q   <= 1'b0;
						unique case (s_tdata[1:0]) inside
							lca_pkg::CMD_STEP: state_q <= ST_SWEEP;
							lca_pkg::CMD_WRITE,
							lca_pkg::CMD_READ,
							lca_pkg::CMD_SPARE: state_q <= ST_FETCH;
							default: state_q <= ST_FETCH;
						endcase
					end
				end
				ST_SWEEP: begin
					if (wr.en && (next_row != here_q)) begin
						changed_q <= 1'b1;
					end
					if (sweep_cnt_q == lca_pkg::CNT_W'(lca_pkg::GRID_HEIGHT + 1)) begin
						state_q <= ST_FETCH;
					end else begin
						sweep_cnt_q <= sweep_cnt_q + lca_pkg::CNT_W'(1);
					end
				end
				ST_FETCH: state_q <= ST_LOAD;
				ST_LOAD:  state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_data_q <= {6'b0, res_changed_q, res_state_q};
		end
	end

`ifndef SYNTH
	// no row is written while waiting for a command
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !wr.en)
		else $error("row write while idle");

	// the sweep never reads the row it is writing back
	assert property (@(posedge clk) disable iff (!arst_n)
		(wr.en && rd.en) |-> (wr.addr != rd.addr))
		else $error("row read and write collide");

	// the sweep counter stays within the window of the grid
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP) |-> (sweep_cnt_q <= lca_pkg::CNT_W'(lca_pkg::GRID_HEIGHT + 1)))
		else $error("sweep counter overrun");

	// a command in progress blocks the next transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("ready right after a transaction");
`endif

endmodule
